### sv/adnp_pkg.sv
// ----------------------------------------------------------------------------
// adnp_pkg
// Shared types and constants of the ASCII decimal number parser: character
// codes, register indexes, the result word and the mantissa cap function.
// ----------------------------------------------------------------------------
package adnp_pkg;

  // Field widths
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned MANT_W  = 30;
  localparam int unsigned FRAC_W  = 4;
  localparam int unsigned INDEX_W = 8;
  localparam int unsigned REG_W   = 2;

  // Character codes
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

  // Register reset values
  localparam logic [CHAR_W-1:0] FIRST_DELIM_RST  = 8'h3D;
  localparam logic [CHAR_W-1:0] SECOND_DELIM_RST = 8'h3E;
  localparam logic [CHAR_W-1:0] LINE_END_RST     = 8'h0D;

  // Register indexes
  localparam logic [REG_W-1:0] REG_FIRST_DELIM  = 2'd0;
  localparam logic [REG_W-1:0] REG_SECOND_DELIM = 2'd1;
  localparam logic [REG_W-1:0] REG_LINE_END     = 2'd2;

  // Largest fraction digit count
  localparam logic [FRAC_W-1:0] FRAC_MAX = 4'd15;

  // One result word
  typedef struct packed {
    logic               has_number;
    logic               negative;
    logic [MANT_W-1:0]  mantissa;
    logic [FRAC_W-1:0]  frac_digits;
    logic               overflow;
    logic [INDEX_W-1:0] value_index;
    logic               last;
  } adnp_result_t;

  // 10^digits - 1, digits clamped to 1..18, result clamped to the mantissa width
  function automatic logic [MANT_W-1:0] mant_cap(input int digits);
    logic [63:0] v;
    int          d;
    v = 64'd1;
    d = digits;
    if (d < 1) d = 1;
    if (d > 18) d = 18;
    for (int k = 0; k < 18; k++) begin
      if (k < d) v = v * 64'd10;
    end
    v = v - 64'd1;
    if (v > {{(64-MANT_W){1'b0}}, {MANT_W{1'b1}}}) v = {{(64-MANT_W){1'b0}}, {MANT_W{1'b1}}};
    return v[MANT_W-1:0];
  endfunction

endpackage

### sv/adnp_char_if.sv
// ----------------------------------------------------------------------------
// adnp_char_if
// Character channel: one received ASCII character per word.
// ----------------------------------------------------------------------------
interface adnp_char_if;
  logic                           valid;
  logic                           ready;
  logic [adnp_pkg::CHAR_W-1:0]    char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

### sv/adnp_result_if.sv
// ----------------------------------------------------------------------------
// adnp_result_if
// Result channel: one parsed number, or a bare line end, per word.
// ----------------------------------------------------------------------------
interface adnp_result_if;
  logic                           valid;
  logic                           ready;
  logic                           has_number;
  logic                           negative;
  logic [adnp_pkg::MANT_W-1:0]    mantissa;
  logic [adnp_pkg::FRAC_W-1:0]    frac_digits;
  logic                           overflow;
  logic [adnp_pkg::INDEX_W-1:0]   value_index;
  logic                           last;

  modport source (output valid, output has_number, output negative, output mantissa,
                  output frac_digits, output overflow, output value_index,
                  output last, input ready);
  modport sink   (input valid, input has_number, input negative, input mantissa,
                  input frac_digits, input overflow, input value_index,
                  input last, output ready);
endinterface

### sv/adnp_cfg_if.sv
// ----------------------------------------------------------------------------
// adnp_cfg_if
// Configuration write channel: register index and write data per word.
// ----------------------------------------------------------------------------
interface adnp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [adnp_pkg::REG_W-1:0]     index;
  logic [adnp_pkg::CHAR_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/ascii_decimal_number_parser_unit.sv
// ----------------------------------------------------------------------------
// ascii_decimal_number_parser_unit
// Character-stream decimal number parser with configurable delimiters.
// ----------------------------------------------------------------------------
// Takes one character per cycle and sustains that rate while results are
// taken. A character passes an input register, then the parse step (compare
// against the delimiters and specials, multiply-by-ten-and-add on the 30-bit
// mantissa with a cap check) writes the parser state and, where a number
// closes, the result register. A result held back by the sink stalls the
// parse step; one more character waits in the input register before
// chars.ready drops. Configuration writes are taken at any time, one per
// cycle.
module ascii_decimal_number_parser_unit #(
  parameter int MAX_DIGITS = 9
) (
  input  logic                  clk,
  input  logic                  rst,
  adnp_char_if.sink             chars,
  adnp_result_if.source         results,
  adnp_cfg_if.sink              cfg
);

  localparam logic [adnp_pkg::MANT_W-1:0] CAP = adnp_pkg::mant_cap(MAX_DIGITS);

  // Parse mode codes
  localparam logic MODE_SEEK = 1'b0;
  localparam logic MODE_LINE = 1'b1;

  // Configuration registers
  logic [adnp_pkg::CHAR_W-1:0] first_delim;
  logic [adnp_pkg::CHAR_W-1:0] second_delim;
  logic [adnp_pkg::CHAR_W-1:0] line_end;

  // Input register
  logic                        char_valid;
  logic [adnp_pkg::CHAR_W-1:0] char_q;

  // Parser state
  logic                         mode, mode_next;
  logic [adnp_pkg::MANT_W-1:0]  acc_mant, acc_mant_next;
  logic [adnp_pkg::FRAC_W-1:0]  acc_frac, acc_frac_next;
  logic                         acc_neg, acc_neg_next;
  logic                         point_seen, point_seen_next;
  logic                         pending, pending_next;
  logic                         acc_ovf, acc_ovf_next;
  logic [adnp_pkg::INDEX_W-1:0] line_index, line_index_next;

  // Result register
  logic                   out_valid;
  adnp_pkg::adnp_result_t out_q;

  // Parse step controls
  logic stage_fire;
  logic emit, emit_has;
  logic emit_last;

  // Digit path
  logic                          char_is_num;
  logic [3:0]                    digit;
  logic [adnp_pkg::MANT_W-1:0]   base_mant;
  logic [adnp_pkg::FRAC_W-1:0]   base_frac;
  logic                          base_ovf, base_point;
  logic [adnp_pkg::MANT_W+3:0]   prod;
  logic [adnp_pkg::MANT_W-1:0]   dig_mant;
  logic [adnp_pkg::FRAC_W-1:0]   dig_frac;
  logic                          dig_ovf;
  logic [adnp_pkg::INDEX_W-1:0]  index_inc;

  // Handshakes
  assign stage_fire    = char_valid && (!out_valid || results.ready);
  assign chars.ready   = !char_valid || stage_fire;
  assign cfg.ready     = 1'b1;

  // Configuration writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      first_delim  <= adnp_pkg::FIRST_DELIM_RST;
      second_delim <= adnp_pkg::SECOND_DELIM_RST;
      line_end     <= adnp_pkg::LINE_END_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        adnp_pkg::REG_FIRST_DELIM:  first_delim  <= cfg.data;
        adnp_pkg::REG_SECOND_DELIM: second_delim <= cfg.data;
        adnp_pkg::REG_LINE_END:     line_end     <= cfg.data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (chars.ready) begin
      char_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      char_q <= chars.char_in;
    end
  end

  // Digit accumulate: start from a cleared number when none is pending
  assign char_is_num = (char_q >= adnp_pkg::CHAR_ZERO) && (char_q <= adnp_pkg::CHAR_NINE);
  assign digit      = 4'(char_q - adnp_pkg::CHAR_ZERO);
  assign base_mant  = pending ? acc_mant : '0;
  assign base_frac  = pending ? acc_frac : '0;
  assign base_ovf   = pending && acc_ovf;
  assign base_point = pending && point_seen;
  assign prod       = {1'b0, base_mant, 3'b000} + {3'b000, base_mant, 1'b0}
                    + {{adnp_pkg::MANT_W{1'b0}}, digit};

  always_comb begin
    dig_mant = base_mant;
    dig_frac = base_frac;
    dig_ovf  = base_ovf;
    if (!base_ovf) begin
      if (base_point && base_frac == adnp_pkg::FRAC_MAX) begin
        dig_ovf = 1'b1;
      end else if (prod > {4'b0000, CAP}) begin
        dig_mant = CAP;
        dig_ovf  = 1'b1;
      end else begin
        dig_mant = prod[adnp_pkg::MANT_W-1:0];
        if (base_point) dig_frac = base_frac + 4'd1;
      end
    end
  end

  // Saturating count of numbers in the line
  assign index_inc = (line_index == {adnp_pkg::INDEX_W{1'b1}}) ? line_index
                                                               : line_index + 8'd1;

  // Parse step
  always_comb begin
    mode_next       = mode;
    acc_mant_next   = acc_mant;
    acc_frac_next   = acc_frac;
    acc_neg_next    = acc_neg;
    point_seen_next = point_seen;
    pending_next    = pending;
    acc_ovf_next    = acc_ovf;
    line_index_next = line_index;
    emit            = 1'b0;
    emit_has        = 1'b0;
    emit_last       = 1'b0;

    if (mode == MODE_SEEK) begin
      if (char_q == first_delim || char_q == second_delim) begin
        mode_next       = MODE_LINE;
        acc_mant_next   = '0;
        acc_frac_next   = '0;
        acc_neg_next    = 1'b0;
        point_seen_next = 1'b0;
        pending_next    = 1'b0;
        acc_ovf_next    = 1'b0;
        line_index_next = '0;
      end
    end else begin
      priority if (char_q == line_end) begin
        emit            = 1'b1;
        emit_has        = pending;
        emit_last       = 1'b1;
        mode_next       = MODE_SEEK;
        acc_mant_next   = '0;
        acc_frac_next   = '0;
        acc_neg_next    = 1'b0;
        point_seen_next = 1'b0;
        pending_next    = 1'b0;
        acc_ovf_next    = 1'b0;
        line_index_next = '0;
      end else if (char_q == adnp_pkg::CHAR_MINUS || char_q == adnp_pkg::CHAR_PLUS) begin
        // sign closes any pending number and opens a new one
        emit            = pending;
        emit_has        = pending;
        line_index_next = pending ? index_inc : line_index;
        acc_mant_next   = '0;
        acc_frac_next   = '0;
        acc_neg_next    = (char_q == adnp_pkg::CHAR_MINUS);
        point_seen_next = 1'b0;
        pending_next    = 1'b1;
        acc_ovf_next    = 1'b0;
      end else if (char_is_num) begin
        pending_next    = 1'b1;
        acc_neg_next    = pending && acc_neg;
        point_seen_next = base_point;
        acc_mant_next   = dig_mant;
        acc_frac_next   = dig_frac;
        acc_ovf_next    = dig_ovf;
      end else if (char_q == adnp_pkg::CHAR_POINT) begin
        if (pending && !point_seen) begin
          point_seen_next = 1'b1;
        end else begin
          // lone or second point: close any number, reopen with point seen
          emit            = pending;
          emit_has        = pending;
          line_index_next = pending ? index_inc : line_index;
          acc_mant_next   = '0;
          acc_frac_next   = '0;
          acc_neg_next    = 1'b0;
          point_seen_next = 1'b1;
          pending_next    = 1'b1;
          acc_ovf_next    = 1'b0;
        end
      end else begin
        // separator
        emit            = pending;
        emit_has        = pending;
        line_index_next = pending ? index_inc : line_index;
        acc_mant_next   = '0;
        acc_frac_next   = '0;
        acc_neg_next    = 1'b0;
        point_seen_next = 1'b0;
        pending_next    = 1'b0;
        acc_ovf_next    = 1'b0;
      end
    end
  end

  // Parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_SEEK;
      acc_mant   <= '0;
      acc_frac   <= '0;
      acc_neg    <= 1'b0;
      point_seen <= 1'b0;
      pending    <= 1'b0;
      acc_ovf    <= 1'b0;
      line_index <= '0;
    end else if (stage_fire) begin
      mode       <= mode_next;
      acc_mant   <= acc_mant_next;
      acc_frac   <= acc_frac_next;
      acc_neg    <= acc_neg_next;
      point_seen <= point_seen_next;
      pending    <= pending_next;
      acc_ovf    <= acc_ovf_next;
      line_index <= line_index_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_fire) begin
      out_valid <= emit;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_fire && emit) begin
      out_q.has_number  <= emit_has;
      out_q.negative    <= emit_has && acc_neg;
      out_q.mantissa    <= emit_has ? acc_mant : '0;
      out_q.frac_digits <= emit_has ? acc_frac : '0;
      out_q.overflow    <= emit_has && acc_ovf;
      out_q.value_index <= line_index;
      out_q.last        <= emit_last;
    end
  end

  assign results.valid       = out_valid;
  assign results.has_number  = out_q.has_number;
  assign results.negative    = out_q.negative;
  assign results.mantissa    = out_q.mantissa;
  assign results.frac_digits = out_q.frac_digits;
  assign results.overflow    = out_q.overflow;
  assign results.value_index = out_q.value_index;
  assign results.last        = out_q.last;

`ifndef ASSERT_OFF
  // a bare line end carries nothing but its index and the last flag
  a_bare_line_end: assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.has_number) |->
      (results.last && results.mantissa == '0 && results.frac_digits == '0
       && !results.negative && !results.overflow))
    else $error("bare line end carries number fields");

  // mantissa never above the cap
  a_mant_cap: assert property (@(posedge clk) disable iff (rst)
    acc_mant <= CAP)
    else $error("accumulated mantissa above cap");

  // fraction digits only after a point
  a_frac_point: assert property (@(posedge clk) disable iff (rst)
    (acc_frac != '0) |-> point_seen)
    else $error("fraction digits without a point");

  // no number held while seeking a delimiter
  a_seek_idle: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_SEEK) |-> !pending)
    else $error("number pending while seeking");

  // a stalled parse step keeps its character
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (char_valid && !stage_fire) |=> (char_valid && $stable(char_q)))
    else $error("input register lost a stalled character");
`endif

endmodule
